// ----- src/framed_command_checksum_parser_macros.svh -----
// Assertion macros used by the parser's top-level RTL
`ifndef FRAMED_COMMAND_CHECKSUM_PARSER_MACROS_SVH
`define FRAMED_COMMAND_CHECKSUM_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("framed command parser: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("framed command parser: next-cycle check failed");

`endif

// ----- src/fcc_pkg.sv -----
package fcc_pkg;

    // Framing and separator bytes
    localparam logic [7:0] CHAR_START   = 8'h3C;
    localparam logic [7:0] CHAR_END     = 8'h3E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SEP     = 8'h2A;

    // Result kinds
    localparam logic [2:0] KIND_KEY      = 3'd0;
    localparam logic [2:0] KIND_OK       = 3'd1;
    localparam logic [2:0] KIND_NO_SEP   = 3'd2;
    localparam logic [2:0] KIND_MISMATCH = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

    // Command table
    localparam int NUM_CMDS  = 6;
    localparam int CMD_MAXCH = 11;

    localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_MAXCH] = '{
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h31, 8'h3A, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54},
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h32, 8'h3A, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54},
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h33, 8'h3A, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54},
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h34, 8'h3A, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54},
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h35, 8'h3A, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54},
        '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h3A, 8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00}
    };

    localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd9};

    typedef logic [NUM_CMDS-1:0] cand_mask_t;

    // One result item
    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] key_byte;
        logic [2:0] command_code;
        logic [7:0] expected_checksum;
        logic [7:0] received_checksum;
    } fcc_result_t;

    // Character of one command at one position; positions past the table read as zero
    function automatic logic [7:0] cmd_char(input logic [2:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos < 4'(CMD_MAXCH) && idx < 3'(NUM_CMDS)) begin
            ch = CMD_TEXT[idx][pos];
        end
        return ch;
    endfunction

    // Hex digit decode: bit 4 set means the byte is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        diff = 8'h00;
        res  = 5'b0_0000;
        case (c) inside
            [8'h30:8'h39]: begin
                diff = c - 8'h30;
                res  = {1'b1, diff[3:0]};
            end
            [8'h61:8'h66]: begin
                diff = c - 8'd87;
                res  = {1'b1, diff[3:0]};
            end
            [8'h41:8'h46]: begin
                diff = c - 8'd55;
                res  = {1'b1, diff[3:0]};
            end
            default: res = 5'b0_0000;
        endcase
        return res;
    endfunction

endpackage

// ----- src/fcc_in_stage.sv -----
module fcc_in_stage
    import fcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Take a new transfer when empty or when the held byte moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the byte until it is processed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// ----- src/fcc_frame_core.sv -----
module fcc_frame_core
    import fcc_pkg::*;
#(
    parameter int MAX_LEN = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output fcc_result_t res
);

    localparam int CNT_W = $clog2(MAX_LEN);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_LEN - 1);

    logic             in_frame_reg,  in_frame_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             sep_reg,       sep_next;
    logic [7:0]       xor_reg,       xor_next;
    logic [1:0]       hex_cnt_reg,   hex_cnt_next;
    logic             hex_stop_reg,  hex_stop_next;
    logic [7:0]       hex_val_reg,   hex_val_next;
    cand_mask_t       cand_reg,      cand_next;
    logic [CNT_W-1:0] cmd_len_reg,   cmd_len_next;

    logic [4:0]  hex_d;
    cand_mask_t  cand_upd;
    logic        match_found;
    logic [2:0]  match_code;

    assign hex_d = hex_decode(rx_byte);

    // Drop the candidates that disagree with this command byte
    always_comb begin
        cand_upd = cand_reg;
        for (int i = 0; i < NUM_CMDS; i++) begin
            if (cmd_len_reg >= CNT_W'(CMD_LEN[i]) ||
                cmd_char(3'(i), cmd_len_reg[3:0]) != rx_byte) begin
                cand_upd[i] = 1'b0;
            end
        end
    end

    // Pick the first surviving command whose length agrees
    always_comb begin
        match_found = 1'b0;
        match_code  = 3'd0;
        for (int i = NUM_CMDS - 1; i >= 0; i--) begin
            if (cand_reg[i] && cmd_len_reg == CNT_W'(CMD_LEN[i])) begin
                match_found = 1'b1;
                match_code  = 3'(i);
            end
        end
    end

    // Frame state update and result for the current byte
    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sep_next      = sep_reg;
        xor_next      = xor_reg;
        hex_cnt_next  = hex_cnt_reg;
        hex_stop_next = hex_stop_reg;
        hex_val_next  = hex_val_reg;
        cand_next     = cand_reg;
        cmd_len_next  = cmd_len_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (step) begin
            if (rx_byte == CHAR_START) begin
                in_frame_next = 1'b1;
                count_next    = '0;
                sep_next      = 1'b0;
                xor_next      = 8'h00;
                hex_cnt_next  = 2'd0;
                hex_stop_next = 1'b0;
                hex_val_next  = 8'h00;
                cand_next     = '1;
                cmd_len_next  = '0;
            end else if (!in_frame_reg) begin
                res_valid        = 1'b1;
                res.result_kind  = KIND_KEY;
                res.key_byte     = rx_byte;
            end else if (rx_byte == CHAR_NEWLINE || rx_byte == CHAR_END) begin
                // Close the frame; an empty one reports nothing
                res_valid = (count_reg != '0);
                if (!sep_reg) begin
                    res.result_kind = KIND_NO_SEP;
                end else begin
                    res.expected_checksum = xor_reg;
                    res.received_checksum = hex_val_reg;
                    if (xor_reg != hex_val_reg) begin
                        res.result_kind = KIND_MISMATCH;
                    end else if (match_found) begin
                        res.result_kind  = KIND_OK;
                        res.command_code = match_code;
                    end else begin
                        res.result_kind = KIND_UNKNOWN;
                    end
                end
                in_frame_next = 1'b0;
                count_next    = '0;
                sep_next      = 1'b0;
                xor_next      = 8'h00;
                hex_cnt_next  = 2'd0;
                hex_stop_next = 1'b0;
                hex_val_next  = 8'h00;
                cand_next     = '1;
                cmd_len_next  = '0;
            end else if (count_reg < COUNT_LIMIT) begin
                count_next = count_reg + 1'b1;
                if (!sep_reg) begin
                    if (rx_byte == CHAR_SEP) begin
                        sep_next = 1'b1;
                    end else begin
                        xor_next     = xor_reg ^ rx_byte;
                        cand_next    = cand_upd;
                        cmd_len_next = cmd_len_reg + 1'b1;
                    end
                end else if (!hex_stop_reg && hex_cnt_reg != 2'd2) begin
                    if (!hex_d[4]) begin
                        hex_stop_next = 1'b1;
                    end else begin
                        hex_val_next = {hex_val_reg[3:0], hex_d[3:0]};
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sep_reg      <= 1'b0;
            xor_reg      <= 8'h00;
            hex_cnt_reg  <= 2'd0;
            hex_stop_reg <= 1'b0;
            hex_val_reg  <= 8'h00;
            cand_reg     <= '1;
            cmd_len_reg  <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            sep_reg      <= sep_next;
            xor_reg      <= xor_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_stop_reg <= hex_stop_next;
            hex_val_reg  <= hex_val_next;
            cand_reg     <= cand_next;
            cmd_len_reg  <= cmd_len_next;
        end
    end

endmodule

// ----- src/fcc_out_stage.sv -----
module fcc_out_stage
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    input  fcc_result_t res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output fcc_result_t m_res
);

    logic        valid_reg;
    logic        valid_next;
    fcc_result_t res_reg;

    // Free when empty or when the held result is taken this cycle
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = out_free ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result only when the register is free
    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ----- src/framed_command_checksum_parser.sv -----
// An accepted byte waits in the input register; its result is then loaded into the
// result register, which feeds the m_ channel. One byte per cycle while it is free;
// the frame state updates in one pass per byte. The registers decouple the channels.
// Reset (aresetn low, synchronous): leaves the frame, clears all frame state,
// sets every command candidate and empties both registers.
`include "framed_command_checksum_parser_macros.svh"

module framed_command_checksum_parser
    import fcc_pkg::*;
#(
    parameter int MAX_LEN = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_result_kind,
    output logic [7:0] m_key_byte,
    output logic [2:0] m_command_code,
    output logic [7:0] m_expected_checksum,
    output logic [7:0] m_received_checksum
);

    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        out_free;
    logic        step;
    logic        res_valid;
    fcc_result_t res;
    fcc_result_t m_res;

    // Register the incoming byte
    fcc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (out_free),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Process the held byte when the result register can take its outcome
    assign step = byte_valid && out_free;

    fcc_frame_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    fcc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_result_kind       = m_res.result_kind;
    assign m_key_byte          = m_res.key_byte;
    assign m_command_code      = m_res.command_code;
    assign m_expected_checksum = m_res.expected_checksum;
    assign m_received_checksum = m_res.received_checksum;

    // A stalled input side means a byte is held waiting
    `FCC_ASSERT_NOW(a_stall_held, aclk, aresetn, !s_ready, byte_valid)
    // A reported command always carries agreeing checksums and a valid code
    `FCC_ASSERT_NOW(a_ok_agree, aclk, aresetn, m_valid && m_result_kind == KIND_OK, m_expected_checksum == m_received_checksum && m_command_code <= 3'd5)
    // A mismatch always carries differing checksums
    `FCC_ASSERT_NOW(a_mismatch_differs, aclk, aresetn, m_valid && m_result_kind == KIND_MISMATCH, m_expected_checksum != m_received_checksum)
    // A processed byte with a result always shows on the output next cycle
    `FCC_ASSERT_NEXT(a_result_loaded, aclk, aresetn, step && res_valid, m_valid)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

import fcc_pkg::*;

// Tracks the frame state byte by byte and holds the outcomes still owed by the parser
class frame_outcome_predictor;
    fcc_result_t outcomes_due[$];
    int          mismatch_count;
    int          store_limit;
    string       cmd_text[NUM_CMDS];

    logic        in_frame;
    logic [6:0]  stored_bytes;
    logic        sep_seen;
    logic [7:0]  text_xor;
    logic [1:0]  digits_taken;
    logic        digits_halted;
    logic [7:0]  sum_field;
    logic [5:0]  still_matching;
    logic [6:0]  text_len;

    function new(int max_len);
        cmd_text = '{"MODE1:START", "MODE2:START", "MODE3:START", "MODE4:START",
                     "MODE5:START", "MODE:STOP"};
        store_limit    = max_len - 1;
        mismatch_count = 0;
        in_frame       = 1'b0;
        clear_frame();
    endfunction

    function void clear_frame();
        stored_bytes   = '0;
        sep_seen       = 1'b0;
        text_xor       = '0;
        digits_taken   = '0;
        digits_halted  = 1'b0;
        sum_field      = '0;
        still_matching = '1;
        text_len       = '0;
    endfunction

    // Fold a command byte into the XOR and drop commands that no longer match
    function void take_text_byte(input logic [7:0] c);
        int i;
        text_xor ^= c;
        for (i = 0; i < NUM_CMDS; i++) begin
            if (text_len >= cmd_text[i].len() || 8'(cmd_text[i][text_len]) != c) begin
                still_matching[i] = 1'b0;
            end
        end
        if (text_len < 7'd127) begin
            text_len++;
        end
    endfunction

    // Take up to two hex digits after the separator; stop at the first non-digit
    function void take_sum_byte(input logic [7:0] c);
        logic [7:0] nib;
        if (digits_halted || digits_taken >= 2'd2) begin
            return;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            nib = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            nib = c - 8'h41 + 8'd10;
        end else begin
            digits_halted = 1'b1;
            return;
        end
        sum_field = {sum_field[3:0], nib[3:0]};
        digits_taken++;
    endfunction

    // Note an accepted input byte and queue the outcome it causes, if any
    function void take_byte(input logic [7:0] c);
        fcc_result_t r;
        int          i;
        r = '0;
        if (c == CHAR_START) begin
            clear_frame();
            in_frame = 1'b1;
            return;
        end
        if (!in_frame) begin
            r.result_kind = KIND_KEY;
            r.key_byte    = c;
            outcomes_due.push_back(r);
            return;
        end
        if (c == CHAR_NEWLINE || c == CHAR_END) begin
            if (stored_bytes != 0) begin
                if (!sep_seen) begin
                    r.result_kind = KIND_NO_SEP;
                end else begin
                    r.expected_checksum = text_xor;
                    r.received_checksum = sum_field;
                    if (text_xor != sum_field) begin
                        r.result_kind = KIND_MISMATCH;
                    end else begin
                        r.result_kind = KIND_UNKNOWN;
                        // lowest matching index wins
                        for (i = NUM_CMDS - 1; i >= 0; i--) begin
                            if (still_matching[i] && text_len == cmd_text[i].len()) begin
                                r.result_kind  = KIND_OK;
                                r.command_code = 3'(i);
                            end
                        end
                    end
                end
                outcomes_due.push_back(r);
            end
            in_frame = 1'b0;
            clear_frame();
            return;
        end
        // drop bytes once the frame store is full
        if (stored_bytes < store_limit) begin
            stored_bytes++;
            if (!sep_seen) begin
                if (c == CHAR_SEP) begin
                    sep_seen = 1'b1;
                end else begin
                    take_text_byte(c);
                end
            end else begin
                take_sum_byte(c);
            end
        end
    endfunction

    task flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Compare a result transfer against the oldest outstanding outcome
    task match_outcome(input fcc_result_t got);
        fcc_result_t want;
        if (outcomes_due.size() == 0) begin
            flag_mismatch($sformatf("result of kind %0d with nothing outstanding",
                                    got.result_kind));
            return;
        end
        want = outcomes_due.pop_front();
        compare_field("result_kind", 8'(got.result_kind), 8'(want.result_kind));
        compare_field("key_byte", got.key_byte, want.key_byte);
        compare_field("command_code", 8'(got.command_code), 8'(want.command_code));
        compare_field("expected_checksum", got.expected_checksum, want.expected_checksum);
        compare_field("received_checksum", got.received_checksum, want.received_checksum);
    endtask
endclass

module tb;
    localparam int FRAME_MAX    = 128;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BYTES  = 380;
    localparam int DRAIN_CYCLES = 10;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [2:0] m_result_kind;
    logic [7:0] m_key_byte;
    logic [2:0] m_command_code;
    logic [7:0] m_expected_checksum;
    logic [7:0] m_received_checksum;

    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;
    int         quiet_cycles  = 0;
    logic [7:0] byte_stream[$];

    frame_outcome_predictor pred;

    framed_command_checksum_parser #(
        .MAX_LEN(FRAME_MAX)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_key_byte         (m_key_byte),
        .m_command_code     (m_command_code),
        .m_expected_checksum(m_expected_checksum),
        .m_received_checksum(m_received_checksum)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Check each result transfer, then choose the next ready level
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                pred.match_outcome({m_result_kind, m_key_byte, m_command_code,
                                    m_expected_checksum, m_received_checksum});
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // End the run when no transfer has happened for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Any byte that is not a frame delimiter, optionally excluding the separator
    function automatic logic [7:0] plain_byte(input bit allow_sep);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_START || b == CHAR_END || b == CHAR_NEWLINE ||
               (!allow_sep && b == CHAR_SEP));
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    task automatic append_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            byte_stream.push_back(s[k]);
        end
    endtask

    task automatic append_close();
        byte_stream.push_back($urandom_range(1) ? CHAR_END : CHAR_NEWLINE);
    endtask

    // Separator and checksum digits: none, one or two, sometimes with a trailing byte
    task automatic append_sum(input logic [7:0] check_val);
        int mode;
        mode = $urandom_range(9);
        byte_stream.push_back(CHAR_SEP);
        if (!(mode == 0 && check_val == 8'h00)) begin
            if (mode <= 1 && check_val < 8'h10) begin
                byte_stream.push_back(hex_char(check_val[3:0]));
            end else begin
                byte_stream.push_back(hex_char(check_val[7:4]));
                byte_stream.push_back(hex_char(check_val[3:0]));
            end
        end
        case (mode)
            7: byte_stream.push_back(hex_char(4'($urandom_range(15))));
            8: byte_stream.push_back(CHAR_SEP);
            9: byte_stream.push_back(plain_byte(1'b1));
            default: ;
        endcase
    endtask

    // One random frame, or a burst of bytes outside any frame
    task automatic add_frame();
        int         pick;
        int         idx;
        int         n;
        logic [7:0] b;
        logic [7:0] check_val;
        logic [7:0] text[$];
        pick = $urandom_range(99);
        idx  = $urandom_range(NUM_CMDS - 1);
        if (pick >= 93) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                do
                    b = 8'($urandom_range(255));
                while (b == CHAR_START);
                byte_stream.push_back(b);
            end
            return;
        end
        // abandon a partial frame; the next start byte restarts it
        if (pick >= 85 && pick < 89) begin
            byte_stream.push_back(CHAR_START);
            n = $urandom_range(1, 6);
            repeat (n) byte_stream.push_back(plain_byte(1'b1));
            pick = 0;
        end
        byte_stream.push_back(CHAR_START);
        if (pick >= 89) begin
            append_close();
            return;
        end
        // free text, without a separator or with any number of them
        if (pick >= 73) begin
            n = $urandom_range(1, 20);
            repeat (n) byte_stream.push_back(plain_byte(pick >= 79));
            append_close();
            return;
        end
        for (n = 0; n < pred.cmd_text[idx].len(); n++) begin
            text.push_back(pred.cmd_text[idx][n]);
        end
        if (pick >= 45 && pick < 55) begin
            text[$urandom_range(text.size() - 1)] = plain_byte(1'b0);
        end else if (pick >= 55 && pick < 65) begin
            if ($urandom_range(1)) begin
                text.push_back(plain_byte(1'b0));
            end else begin
                n = $urandom_range(text.size() - 1);
                while (text.size() > n) void'(text.pop_back());
            end
        end
        check_val = 8'h00;
        foreach (text[k]) check_val ^= text[k];
        if (pick >= 65) begin
            check_val ^= 8'($urandom_range(1, 255));
        end
        foreach (text[k]) byte_stream.push_back(text[k]);
        append_sum(check_val);
        append_close();
    endtask

    // Frame that runs up against the store limit; the offset moves the separator across it
    task automatic add_long_frame(input int offset);
        int n;
        n = FRAME_MAX - 3 + offset;
        byte_stream.push_back(CHAR_START);
        repeat (n) byte_stream.push_back(plain_byte(1'b0));
        append_sum(8'($urandom_range(255)));
        append_close();
    endtask

    // Hold the byte on the input until the transfer completes
    task automatic send_byte(input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        pred.take_byte(b);
    endtask

    initial begin
        pred = new(FRAME_MAX);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // key bytes at the extremes, then empty, restarted, bare-separator and short frames
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(CHAR_END);
        byte_stream.push_back(CHAR_NEWLINE);
        byte_stream.push_back(CHAR_SEP);
        append_text("<><AB<*><*00");
        byte_stream.push_back(CHAR_NEWLINE);
        append_text("<Q><A*42>");

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 37 : (phase == 1) ? 83 : 0;
            sink_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 37 : 0;
            add_long_frame(phase);
            while (byte_stream.size() < PHASE_BYTES) add_frame();
            while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
        end
        s_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pred.outcomes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pred.mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/fcc_pkg.sv
src/fcc_in_stage.sv
src/fcc_frame_core.sv
src/fcc_out_stage.sv
src/framed_command_checksum_parser.sv
sim/tb.sv
